### rtl/dcmf_pkg.sv
// package: message types, character codes and formatting constants
`default_nettype none
package dcmf_pkg;

    // message geometry
    localparam int MSG_BYTES = 9;
    localparam int MSG_IDX_W = $clog2(MSG_BYTES);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // op codes
    localparam logic OP_ONE_NUM = 1'b0;
    localparam logic OP_TWO_NUM = 1'b1;

    // characters
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LF    = 8'h0a;

    // number limits and reciprocal of one hundred (v * 41 >> 12 for v < 1000)
    localparam logic [9:0]  NUMBER_MAX  = 10'd999;
    localparam logic [15:0] RECIP_100   = 16'd41;
    localparam int          RECIP_SHIFT = 12;

    // one formatted message, byte 0 goes out first
    typedef struct packed {
        logic [MSG_IDX_W-1:0]           last_idx;
        logic [MSG_BYTES-1:0][7:0]      bytes;
    } t_msg;

    // write side of the queue
    typedef struct packed {
        logic valid;
        t_msg msg;
    } t_q_wr;

    // head of the queue
    typedef struct packed {
        logic valid;
        t_msg msg;
    } t_q_head;

endpackage
`default_nettype wire

### rtl/dcmf_if.sv
// interfaces: input item channel and output byte channel
`default_nettype none
interface dcmf_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] command_char;
    logic [7:0] number_a;
    logic [9:0] number_b;

    modport source (output valid, output op, output command_char, output number_a,
                    output number_b, input ready);
    modport sink   (input valid, input op, input command_char, input number_a,
                    input number_b, output ready);
endinterface

interface dcmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### rtl/dcmf_front.sv
// front: accepts items, splits numbers into digits and builds the message
`default_nettype none
module dcmf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    dcmf_in_if.sink            i_in,
    output dcmf_pkg::t_q_wr    o_wr,
    input  wire logic          i_wr_ready
);
    import dcmf_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] cmd;
        logic [9:0] num_a;
        logic [3:0] hund_a;
        logic [9:0] num_b;
        logic [3:0] hund_b;
    } t_s1;

    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][7:0] ch;
    } t_num;

    logic        r_s1_valid;
    logic        n_s1_valid;
    t_s1         r_s1;
    t_s1         n_s1;
    logic [9:0]  clamped_b;
    logic [15:0] prod_a;
    logic [15:0] prod_b;
    t_num        dig_a;
    t_num        dig_b;
    t_msg        msg;

    // digits of a value below 1000 given its hundreds digit
    function automatic t_num to_digits(input logic [9:0] v, input logic [3:0] h);
        logic [9:0] diff;
        logic [6:0] rem;
        logic [6:0] ones_w;
        logic [3:0] t;
        logic [3:0] o;
        t_num       r;
        diff = v - ((10'(h) << 6) + (10'(h) << 5) + (10'(h) << 2));
        rem  = diff[6:0];
        t    = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (rem >= 7'(i * 10)) begin
                t = 4'(i);
            end
        end
        ones_w = rem - (7'(t) << 3) - (7'(t) << 1);
        o      = ones_w[3:0];
        r      = '0;
        if (h != 4'd0) begin
            r.len   = 2'd3;
            r.ch[0] = CHAR_ZERO + {4'd0, h};
            r.ch[1] = CHAR_ZERO + {4'd0, t};
            r.ch[2] = CHAR_ZERO + {4'd0, o};
        end else if (t != 4'd0) begin
            r.len   = 2'd2;
            r.ch[0] = CHAR_ZERO + {4'd0, t};
            r.ch[1] = CHAR_ZERO + {4'd0, o};
        end else begin
            r.len   = 2'd1;
            r.ch[0] = CHAR_ZERO + {4'd0, o};
        end
        return r;
    endfunction

    // stage 1: clamp and hundreds digit by reciprocal multiply
    always_comb begin
        clamped_b   = (i_in.number_b > NUMBER_MAX) ? NUMBER_MAX : i_in.number_b;
        prod_a      = 16'(i_in.number_a) * RECIP_100;
        prod_b      = 16'(clamped_b) * RECIP_100;
        n_s1.op     = i_in.op;
        n_s1.cmd    = i_in.command_char;
        n_s1.num_a  = {2'd0, i_in.number_a};
        n_s1.hund_a = prod_a[RECIP_SHIFT +: 4];
        n_s1.num_b  = clamped_b;
        n_s1.hund_b = prod_b[RECIP_SHIFT +: 4];
    end

    assign i_in.ready = !r_s1_valid || i_wr_ready;
    assign n_s1_valid = i_in.ready ? i_in.valid : r_s1_valid;

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: tens and ones, then lay out the message bytes
    always_comb begin
        logic [MSG_IDX_W-1:0] k;
        dig_a = to_digits(r_s1.num_a, r_s1.hund_a);
        dig_b = to_digits(r_s1.num_b, r_s1.hund_b);
        msg          = '0;
        msg.bytes[0] = r_s1.cmd;
        k            = MSG_IDX_W'(1);
        if (r_s1.op == OP_TWO_NUM) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < dig_a.len) begin
                    msg.bytes[k] = dig_a.ch[i];
                    k            = k + MSG_IDX_W'(1);
                end
            end
            msg.bytes[k] = CHAR_SPACE;
            k            = k + MSG_IDX_W'(1);
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < dig_b.len) begin
                msg.bytes[k] = dig_b.ch[i];
                k            = k + MSG_IDX_W'(1);
            end
        end
        msg.bytes[k] = CHAR_LF;
        msg.last_idx = k;
    end

    assign o_wr.valid = r_s1_valid;
    assign o_wr.msg   = msg;

endmodule
`default_nettype wire

### rtl/dcmf_queue.sv
// queue: short message fifo between front and back
`default_nettype none
module dcmf_queue #(
    parameter int DEPTH = dcmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dcmf_pkg::t_q_wr i_wr,
    output logic               o_wr_ready,
    output dcmf_pkg::t_q_head  o_head,
    input  wire logic          i_pop
);
    import dcmf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_msg             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_wr_ready  = (r_count != CNT_W'(DEPTH));
    assign do_wr       = i_wr.valid && o_wr_ready;
    assign do_rd       = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.msg   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.msg;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!do_wr && do_rd) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### rtl/dcmf_back.sv
// back: walks the head message and sends one byte per cycle while the output is ready
`default_nettype none
module dcmf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dcmf_pkg::t_q_head i_head,
    output logic               o_pop,
    dcmf_out_if.source         o_out
);
    import dcmf_pkg::*;

    logic [MSG_IDX_W-1:0] r_idx;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;
    logic                 load;
    logic                 at_last;

    assign load    = i_head.valid && (!r_out_valid || o_out.ready);
    assign at_last = (r_idx == i_head.msg.last_idx);
    assign o_pop   = load && at_last;

    // byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= at_last ? '0 : r_idx + MSG_IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.msg.bytes[r_idx];
            r_out_last <= at_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.last_byte = r_out_last;

endmodule
`default_nettype wire

### rtl/decimal_command_message_formatter.sv
// top level: command message formatter, front, queue and back
// a message passes the stage 1 register, the queue and the output register
// one byte per cycle while the output is ready; a message is 3 to 9 bytes long
// the front takes an item every cycle until the message queue fills
// the queue depth (QUEUE_DEPTH messages) sets how far the front runs ahead
// reset: synchronous active low, empties the queue and drops all pending bytes
`default_nettype none
module decimal_command_message_formatter #(
    parameter int QUEUE_DEPTH = dcmf_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dcmf_in_if.sink   i_in,
    dcmf_out_if.source o_out
);
    import dcmf_pkg::*;

    t_q_wr   q_wr;
    logic    q_wr_ready;
    t_q_head q_head;
    logic    q_pop;

    // accept and format
    dcmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_wr       (q_wr),
        .i_wr_ready (q_wr_ready)
    );

    // message queue
    dcmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .o_wr_ready (q_wr_ready),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    // byte sender
    dcmf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

### rtl/dcmf_checker.sv
// checker: assertions on the output channel of the formatter, with its bind
`default_nettype none
module dcmf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       i_ready,
    input wire logic [7:0] i_byte,
    input wire logic       i_last
);
    import dcmf_pkg::*;

    // a stalled item keeps valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("output valid dropped while stalled");

    // a stalled item keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_byte) && $stable(i_last))
        else $error("output payload changed while stalled");

    // a message always ends on a newline
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_byte == CHAR_LF)
        else $error("last byte of a message is not a newline");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind decimal_command_message_formatter dcmf_checker u_dcmf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_byte  (o_out.out_byte),
    .i_last  (o_out.last_byte)
);
`default_nettype wire
